/* design/hpyob_pkg.sv */
// shared types, constants and palette rom for the heat overlay blender
`timescale 1ns / 1ps
`default_nettype none

package hpyob_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int WEIGHT_W   = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_ON    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_WEIGHT = 1'b1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = 9'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd128;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef rgb_t [255:0] palette_t;

  typedef struct packed {
    logic [7:0] u;
    logic [7:0] luma_first;
    logic [7:0] v;
    logic [7:0] luma_second;
  } yuv_word_t;

  typedef struct packed {
    logic [7:0] heat_first;
    logic [7:0] heat_second;
    logic       text_first;
    logic       text_second;
    yuv_word_t  cam;
  } pix_in_t;

  typedef struct packed {
    rgb_t      first;
    rgb_t      second;
    yuv_word_t cam;
  } rgb_pair_t;

  // constant-coefficient products, all below 2^16
  typedef struct packed {
    logic [2:0][15:0] y0_terms;
    logic [2:0][15:0] y1_terms;
    logic [2:0][15:0] u_terms;
    logic [2:0][15:0] v_terms;
    yuv_word_t        cam;
  } prod_t;

  typedef struct packed {
    yuv_word_t ov;
    yuv_word_t cam;
  } ov_pair_t;

  // ramp levels floor(255*sin^2(pi*m/255)) from a cosine recurrence in q60
  function automatic palette_t build_palette();
    logic        [127:0]       x;
    logic        [127:0]       x2;
    logic        [127:0]       term;
    logic        [127:0]       cos_step;
    logic signed [127:0]       one_s;
    logic signed [127:0]       c_prev;
    logic signed [127:0]       c_cur;
    logic signed [127:0]       c_next;
    logic        [127:0]       acc;
    logic        [127:0][7:0]  lvl;
    logic        [8:0]         k;
    logic        [8:0]         m;
    logic        [7:0]         c;
    palette_t                  p;
    x        = ({64'd0, PI_Q60} * 128'd2) / 128'd255;
    x2       = (x * x) >> 60;
    term     = x2 >> 1;
    cos_step = (128'd1 << 60) - term;
    term     = ((term * x2) >> 60) / 128'd12;
    cos_step = cos_step + term;
    term     = ((term * x2) >> 60) / 128'd30;
    cos_step = cos_step - term;
    term     = ((term * x2) >> 60) / 128'd56;
    cos_step = cos_step + term;
    one_s    = $signed(128'd1 << 60);
    c_prev   = one_s;
    c_cur    = $signed(cos_step);
    lvl      = '0;
    acc      = 128'($unsigned(c_cur));
    acc      = 128'd255 * ((128'd1 << 60) - acc);
    lvl[1]   = acc[68:61];
    for (int j = 2; j < 128; j++) begin
      c_next = (($signed(cos_step) * c_cur) >>> 59) - c_prev;
      c_prev = c_cur;
      c_cur  = c_next;
      acc    = 128'd255 * $unsigned(one_s - c_cur);
      lvl[j] = acc[68:61];
    end
    for (int i = 0; i < 256; i++) begin
      k = 9'(2 * i);
      if (k > 9'd254) begin
        k = k - 9'd255;
      end
      m = (k > 9'd127) ? (9'd255 - k) : k;
      c = lvl[m[6:0]];
      if (i < 64) begin
        p[i] = '{r: 8'd0, g: c, b: 8'd255};
      end else if (i < 128) begin
        p[i] = '{r: 8'd0, g: 8'd255, b: c};
      end else if (i < 192) begin
        p[i] = '{r: c, g: 8'd255, b: 8'd0};
      end else begin
        p[i] = '{r: 8'd255, g: c, b: 8'd0};
      end
    end
    return p;
  endfunction

  localparam palette_t PALETTE = build_palette();

endpackage

`default_nettype wire

/* design/hpyob_palette.sv */
// stage one: palette lookup and text override for both pixels
`timescale 1ns / 1ps
`default_nettype none

module hpyob_palette (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  hpyob_pkg::pix_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output hpyob_pkg::rgb_pair_t out_data
);

  logic                 valid_r;
  hpyob_pkg::rgb_pair_t data_r;
  hpyob_pkg::rgb_pair_t data_nxt;

  localparam hpyob_pkg::rgb_t WHITE = '{r: 8'd255, g: 8'd255, b: 8'd255};

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    data_nxt.first  = in_data.text_first  ? WHITE : hpyob_pkg::PALETTE[in_data.heat_first];
    data_nxt.second = in_data.text_second ? WHITE : hpyob_pkg::PALETTE[in_data.heat_second];
    data_nxt.cam    = in_data.cam;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

/* design/hpyob_csc.sv */
// stages two and three: bt.601 products, then sums, rounding and offsets
`timescale 1ns / 1ps
`default_nettype none

module hpyob_csc (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  hpyob_pkg::rgb_pair_t in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output hpyob_pkg::ov_pair_t  out_data
);

  logic                mul_valid_r;
  hpyob_pkg::prod_t    mul_r;
  hpyob_pkg::prod_t    mul_nxt;
  logic                mul_ready;
  logic                sum_valid_r;
  hpyob_pkg::ov_pair_t sum_r;
  hpyob_pkg::ov_pair_t sum_nxt;
  logic [17:0]         y0_sum;
  logic [17:0]         y1_sum;
  logic [17:0]         u_sum;
  logic [17:0]         v_sum;

  function automatic logic [15:0] kmul(input logic [7:0] a, input logic [7:0] k);
    return {8'd0, a} * {8'd0, k};
  endfunction

  assign mul_ready = !sum_valid_r || out_ready;
  assign in_ready  = !mul_valid_r || mul_ready;

  always_comb begin
    mul_nxt.y0_terms = {kmul(in_data.first.r, 8'd66), kmul(in_data.first.g, 8'd129),
                        kmul(in_data.first.b, 8'd25)};
    mul_nxt.y1_terms = {kmul(in_data.second.r, 8'd66), kmul(in_data.second.g, 8'd129),
                        kmul(in_data.second.b, 8'd25)};
    mul_nxt.u_terms  = {kmul(in_data.first.r, 8'd38), kmul(in_data.first.g, 8'd74),
                        kmul(in_data.first.b, 8'd112)};
    mul_nxt.v_terms  = {kmul(in_data.first.r, 8'd112), kmul(in_data.first.g, 8'd94),
                        kmul(in_data.first.b, 8'd18)};
    mul_nxt.cam      = in_data.cam;
  end

  // luma sums stay below 2^16 and chroma sums (offset by 32896) stay in 0..61456,
  // so the results land in 16..240 and never need clipping
  always_comb begin
    y0_sum = 18'(mul_r.y0_terms[2]) + 18'(mul_r.y0_terms[1]) + 18'(mul_r.y0_terms[0])
           + 18'd128;
    y1_sum = 18'(mul_r.y1_terms[2]) + 18'(mul_r.y1_terms[1]) + 18'(mul_r.y1_terms[0])
           + 18'd128;
    u_sum  = 18'd32896 + 18'(mul_r.u_terms[0]) - 18'(mul_r.u_terms[2])
           - 18'(mul_r.u_terms[1]);
    v_sum  = 18'd32896 + 18'(mul_r.v_terms[2]) - 18'(mul_r.v_terms[1])
           - 18'(mul_r.v_terms[0]);
    sum_nxt.ov.u           = u_sum[15:8];
    sum_nxt.ov.luma_first  = y0_sum[15:8] + 8'd16;
    sum_nxt.ov.v           = v_sum[15:8];
    sum_nxt.ov.luma_second = y1_sum[15:8] + 8'd16;
    sum_nxt.cam            = mul_r.cam;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      sum_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        mul_valid_r <= in_valid;
      end
      if (mul_ready) begin
        sum_valid_r <= mul_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mul_r <= mul_nxt;
    end
    if (mul_ready && mul_valid_r) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_valid = sum_valid_r;
  assign out_data  = sum_r;

endmodule

`default_nettype wire

/* design/hpyob_blend.sv */
// stage four: weighted mix of camera and overlay bytes, output register
`timescale 1ns / 1ps
`default_nettype none

module hpyob_blend (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  [hpyob_pkg::WEIGHT_W-1:0]      weight,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  hpyob_pkg::ov_pair_t                 in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output hpyob_pkg::yuv_word_t                out_data
);

  logic                 valid_r;
  hpyob_pkg::yuv_word_t data_r;
  hpyob_pkg::yuv_word_t data_nxt;

  function automatic logic [7:0] mix(input logic [7:0] cam, input logic [7:0] ov,
                                     input logic [hpyob_pkg::WEIGHT_W-1:0] w);
    logic [16:0] acc;
    acc = {9'd0, cam} * {8'd0, w}
        + {9'd0, ov} * {8'd0, hpyob_pkg::WEIGHT_FULL - w};
    return acc[15:8];
  endfunction

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    data_nxt.u           = mix(in_data.cam.u, in_data.ov.u, weight);
    data_nxt.luma_first  = mix(in_data.cam.luma_first, in_data.ov.luma_first, weight);
    data_nxt.v           = mix(in_data.cam.v, in_data.ov.v, weight);
    data_nxt.luma_second = mix(in_data.cam.luma_second, in_data.ov.luma_second, weight);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

/* design/heatmap_palette_yuv_overlay_blend.sv */
// top level: heat palette overlay converted to yuv and blended into a camera stream
// pipeline: four register stages (palette, products, sums, blend), output from the blend
// register. throughput: one pixel pair per cycle while out_ready holds; a stage
// moves on as soon as the stage after it frees, so a stall only fills bubbles
// reset: synchronous active-low rst_n clears all stage valid bits, sets overlay on and
// camera weight 128; the palette is a constant rom and needs no fill after reset
`timescale 1ns / 1ps
`default_nettype none

module heatmap_palette_yuv_overlay_blend (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [hpyob_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [hpyob_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [7:0]                        in_heat_first,
  input  wire  [7:0]                        in_heat_second,
  input  wire                               in_text_first,
  input  wire                               in_text_second,
  input  wire  [7:0]                        in_cam_u,
  input  wire  [7:0]                        in_cam_luma_first,
  input  wire  [7:0]                        in_cam_v,
  input  wire  [7:0]                        in_cam_luma_second,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [7:0]                        out_u,
  output logic [7:0]                        out_luma_first,
  output logic [7:0]                        out_v,
  output logic [7:0]                        out_luma_second
);

  logic                              overlay_on_r;
  logic [hpyob_pkg::WEIGHT_W-1:0]    camera_weight_r;
  logic [hpyob_pkg::WEIGHT_W-1:0]    weight_eff;
  hpyob_pkg::pix_in_t                pix_in;
  logic                              pal_valid;
  logic                              pal_ready;
  hpyob_pkg::rgb_pair_t              pal_data;
  logic                              csc_valid;
  logic                              csc_ready;
  hpyob_pkg::ov_pair_t               csc_data;
  hpyob_pkg::yuv_word_t              blend_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overlay_on_r    <= 1'b1;
      camera_weight_r <= hpyob_pkg::WEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpyob_pkg::CFG_OVERLAY_ON:    overlay_on_r    <= cfg_data[0];
        hpyob_pkg::CFG_CAMERA_WEIGHT: camera_weight_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // full camera weight reproduces the camera bytes exactly, which covers overlay off and weights above 256
  assign weight_eff = (!overlay_on_r || camera_weight_r > hpyob_pkg::WEIGHT_FULL) ?
                      hpyob_pkg::WEIGHT_FULL : camera_weight_r;

  always_comb begin
    pix_in.heat_first          = in_heat_first;
    pix_in.heat_second         = in_heat_second;
    pix_in.text_first          = in_text_first;
    pix_in.text_second         = in_text_second;
    pix_in.cam.u               = in_cam_u;
    pix_in.cam.luma_first      = in_cam_luma_first;
    pix_in.cam.v               = in_cam_v;
    pix_in.cam.luma_second     = in_cam_luma_second;
  end

  hpyob_palette u_palette (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (pix_in),
    .out_valid (pal_valid),
    .out_ready (pal_ready),
    .out_data  (pal_data)
  );

  hpyob_csc u_csc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pal_valid),
    .in_ready  (pal_ready),
    .in_data   (pal_data),
    .out_valid (csc_valid),
    .out_ready (csc_ready),
    .out_data  (csc_data)
  );

  hpyob_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .weight    (weight_eff),
    .in_valid  (csc_valid),
    .in_ready  (csc_ready),
    .in_data   (csc_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (blend_data)
  );

  assign out_u           = blend_data.u;
  assign out_luma_first  = blend_data.luma_first;
  assign out_v           = blend_data.v;
  assign out_luma_second = blend_data.luma_second;

  // a draining output lets every stage advance, so the input side must be open
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !pal_valid && !csc_valid)
    else $error("pipeline valid survived reset");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    csc_valid |-> weight_eff <= hpyob_pkg::WEIGHT_FULL)
    else $error("blend weight out of range");

endmodule

`default_nettype wire
